FILE: sv/poly_pkg.sv
package poly_pkg;

	localparam int WORD_W   = 32;
	localparam int PROD_W   = 2 * WORD_W;
	localparam int REG_COUNT = 8;
	localparam int IDX_W    = $clog2(REG_COUNT);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// data handed from one cell to the next
	typedef struct packed {
		word_t x;
		word_t acc;
		logic  ovf;
	} token_t;

endpackage

FILE: sv/poly_cell.sv
module poly_cell #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	input  poly_pkg::token_t tok_in,
	input  poly_pkg::word_t  coef,
	output logic             valid_out,
	output poly_pkg::token_t tok_out
);

	logic            valid_s1;
	poly_pkg::prod_t prod_s1;
	poly_pkg::word_t x_s1;
	logic            ovf_s1;

	logic             valid_s2;
	poly_pkg::token_t tok_s2;

	poly_pkg::prod_t shifted;
	logic            mul_clip;
	poly_pkg::word_t mul_sat;
	logic signed [poly_pkg::WORD_W:0] sum;
	logic            add_clip;
	poly_pkg::word_t add_sat;

	// stage 1: exact product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= poly_pkg::prod_t'(tok_in.acc) * poly_pkg::prod_t'(tok_in.x);
		x_s1    <= tok_in.x;
		ovf_s1  <= tok_in.ovf;
	end

	// stage 2: floor shift, clip, add coefficient, clip
	always_comb begin
		shifted  = prod_s1 >>> FRAC_BITS;
		mul_clip = !((&shifted[poly_pkg::PROD_W-1:poly_pkg::WORD_W-1]) ||
			!(|shifted[poly_pkg::PROD_W-1:poly_pkg::WORD_W-1]));
		if (!mul_clip) begin
			mul_sat = shifted[poly_pkg::WORD_W-1:0];
		end else if (shifted[poly_pkg::PROD_W-1]) begin
			mul_sat = poly_pkg::WORD_MIN;
		end else begin
			mul_sat = poly_pkg::WORD_MAX;
		end
		sum      = {mul_sat[poly_pkg::WORD_W-1], mul_sat} + {coef[poly_pkg::WORD_W-1], coef};
		add_clip = sum[poly_pkg::WORD_W] != sum[poly_pkg::WORD_W-1];
		if (!add_clip) begin
			add_sat = sum[poly_pkg::WORD_W-1:0];
		end else if (sum[poly_pkg::WORD_W]) begin
			add_sat = poly_pkg::WORD_MIN;
		end else begin
			add_sat = poly_pkg::WORD_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tok_s2.x   <= x_s1;
		tok_s2.acc <= add_sat;
		tok_s2.ovf <= ovf_s1 | mul_clip | add_clip;
	end

	assign valid_out = valid_s2;
	assign tok_out   = tok_s2;

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2)
		else $error("cell dropped a transfer between stages");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_in |=> !valid_s1)
		else $error("cell created a transfer");

	a_ovf_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ovf_s1 |=> tok_s2.ovf)
		else $error("overflow flag lost in cell");

endmodule

FILE: sv/polynomial_evaluator_core.sv
// throughput: one point per cycle, busy stays low; each cell of the chain has
//   a multiply stage and a shift/saturate/add stage, so the chain sets the latency
// results cannot be stalled: strobe marks each result for exactly one cycle
// reset: arst_n clears all coefficients to zero and empties the chain
module polynomial_evaluator_core #(
	parameter int NUM_COEFFS = 8,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [31:0]    x_value,
	output logic                  strobe,
	output logic signed [31:0]    y_value,
	output logic                  overflow,
	input  logic                  wr_en,
	input  poly_pkg::idx_t        wr_index,
	input  logic signed [31:0]    wr_data
);

	localparam int CELLS = NUM_COEFFS - 1;
	localparam int LAT   = 2 * CELLS;

	poly_pkg::word_t  coef_q [poly_pkg::REG_COUNT];
	logic             valid_c [CELLS+1];
	poly_pkg::token_t tok_c   [CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < poly_pkg::REG_COUNT; i++) begin
				coef_q[i] <= '0;
			end
		end else if (wr_en) begin
			coef_q[wr_index] <= wr_data;
		end
	end

	assign busy = 1'b0;

	// head of the chain starts from the top coefficient
	assign valid_c[0]   = start & ~busy;
	assign tok_c[0].x   = x_value;
	assign tok_c[0].acc = coef_q[poly_pkg::idx_t'(NUM_COEFFS - 1)];
	assign tok_c[0].ovf = 1'b0;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam poly_pkg::idx_t K = poly_pkg::idx_t'(NUM_COEFFS - 2 - i);
		poly_cell #(
			.FRAC_BITS(FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (valid_c[i]),
			.tok_in   (tok_c[i]),
			.coef     (coef_q[K]),
			.valid_out(valid_c[i+1]),
			.tok_out  (tok_c[i+1])
		);
	end

	assign strobe   = valid_c[CELLS];
	assign y_value  = tok_c[CELLS].acc;
	assign overflow = tok_c[CELLS].ovf;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT strobe)
		else $error("accepted point gave no result");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start, LAT))
		else $error("result without an accepted point");

	a_x_carried: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> tok_c[CELLS].x == $past(x_value, LAT))
		else $error("point lost its place in the chain");

endmodule

FILE: tb/tb.sv
module tb;

	localparam int NUM_COEFFS = 8;
	localparam int FRAC_BITS  = 16;
	localparam int LATENCY    = 2 * (NUM_COEFFS - 1);
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_ITEMS = 72;
	localparam poly_pkg::word_t ONE_Q = 32'sh0001_0000;

	typedef struct {
		poly_pkg::word_t y;
		logic            ovf;
	} poly_value_t;

	// horner predictor with its own coefficient copy and the queue of pending values
	class horner_book;
		poly_pkg::word_t coefs [poly_pkg::REG_COUNT];
		poly_value_t     pending_values [$];
		int              fails;

		function new();
			foreach (coefs[i]) coefs[i] = '0;
			fails = 0;
		endfunction

		function void write_coef(poly_pkg::idx_t idx, poly_pkg::word_t data);
			coefs[idx] = data;
		endfunction

		function longint clamp(longint v, inout bit ovf);
			if (v > longint'(poly_pkg::WORD_MAX)) begin
				ovf = 1'b1;
				return longint'(poly_pkg::WORD_MAX);
			end
			if (v < longint'(poly_pkg::WORD_MIN)) begin
				ovf = 1'b1;
				return longint'(poly_pkg::WORD_MIN);
			end
			return v;
		endfunction

		function poly_value_t horner_value(poly_pkg::word_t x);
			poly_value_t r;
			longint      acc;
			longint      prod;
			longint      xv;
			bit          ovf;
			xv  = x;
			acc = coefs[NUM_COEFFS-1];
			ovf = 1'b0;
			for (int k = NUM_COEFFS - 2; k >= 0; k--) begin
				// exact product, floor shift, then clip before and after the add
				prod = (acc * xv) >>> FRAC_BITS;
				prod = clamp(prod, ovf);
				acc  = clamp(prod + longint'(coefs[k]), ovf);
			end
			r.y   = poly_pkg::word_t'(acc);
			r.ovf = ovf;
			return r;
		endfunction

		function void note_point(poly_pkg::word_t x);
			pending_values.insert(pending_values.size(), horner_value(x));
		endfunction

		function void check_result(poly_pkg::word_t y, logic ovf);
			poly_value_t e;
			if (pending_values.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result: y=%h overflow=%b", y, ovf);
				return;
			end
			e = pending_values.pop_front();
			if (y !== e.y || ovf !== e.ovf) begin
				fails++;
				if (fails <= 10)
					$display("mismatch: expected y=%h overflow=%b, got y=%h overflow=%b",
						e.y, e.ovf, y, ovf);
			end
		endfunction

		function int pending();
			return pending_values.size();
		endfunction
	endclass

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            start    = 1'b0;
	logic            busy;
	poly_pkg::word_t x_value  = '0;
	logic            strobe;
	poly_pkg::word_t y_value;
	logic            overflow;
	logic            wr_en    = 1'b0;
	poly_pkg::idx_t  wr_index = '0;
	poly_pkg::word_t wr_data  = '0;

	horner_book      book = new();
	poly_pkg::word_t coef_plan [poly_pkg::REG_COUNT];

	polynomial_evaluator_core #(
		.NUM_COEFFS(NUM_COEFFS),
		.FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.x_value (x_value),
		.strobe  (strobe),
		.y_value (y_value),
		.overflow(overflow),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en)
				book.write_coef(wr_index, wr_data);
			if (start && !busy)
				book.note_point(x_value);
			if (strobe)
				book.check_result(y_value, overflow);
		end
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || strobe || wr_en)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	function automatic poly_pkg::word_t rand_point();
		case ($urandom_range(0, 9))
			0: return poly_pkg::WORD_MAX;
			1: return poly_pkg::WORD_MIN;
			2, 3: return poly_pkg::word_t'($urandom);
			4, 5, 6: return poly_pkg::word_t'(int'($urandom_range(0, 262144)) - 131072);
			7, 8: return poly_pkg::word_t'(int'($urandom_range(0, 32768)) - 16384);
			default: return poly_pkg::word_t'(int'($urandom_range(0, 2097152)) - 1048576);
		endcase
	endfunction

	function automatic poly_pkg::word_t rand_coef();
		case ($urandom_range(0, 11))
			0: return poly_pkg::WORD_MAX;
			1: return poly_pkg::WORD_MIN;
			2, 3: return '0;
			4: return poly_pkg::word_t'($urandom);
			5, 6, 7: return poly_pkg::word_t'(int'($urandom_range(0, 262144)) - 131072);
			8, 9: return poly_pkg::word_t'(int'($urandom_range(0, 65536)) - 32768);
			default: return poly_pkg::word_t'(int'($urandom_range(0, 16777216)) - 8388608);
		endcase
	endfunction

	// hold start low until every pending value has come back, then let the chain settle
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic load_plan();
		for (int i = 0; i < poly_pkg::REG_COUNT; i++) begin
			wr_en    <= 1'b1;
			wr_index <= poly_pkg::idx_t'(i);
			wr_data  <= coef_plan[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic send_point(input poly_pkg::word_t x, input bit gaps);
		while (gaps && $urandom_range(0, 99) < 31) begin
			start   <= 1'b0;
			x_value <= poly_pkg::word_t'($urandom);
			@(posedge clk);
		end
		start   <= 1'b1;
		x_value <= x;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	initial begin
		int deg;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficients straight out of reset give zero everywhere
		send_point(poly_pkg::WORD_MAX, 1'b1);
		send_point('0, 1'b1);

		// identity polynomial y = x
		drain();
		foreach (coef_plan[i]) coef_plan[i] = '0;
		coef_plan[1] = ONE_Q;
		load_plan();
		send_point(poly_pkg::WORD_MIN, 1'b1);
		send_point(poly_pkg::WORD_MAX, 1'b1);
		send_point(-32'sd1, 1'b1);
		send_point(32'sd1, 1'b1);
		send_point(ONE_Q, 1'b1);

		// every coefficient at the positive rail
		drain();
		foreach (coef_plan[i]) coef_plan[i] = poly_pkg::WORD_MAX;
		load_plan();
		send_point(poly_pkg::WORD_MAX, 1'b1);
		send_point('0, 1'b1);
		send_point(-32'sd1, 1'b1);

		// every coefficient at the negative rail
		drain();
		foreach (coef_plan[i]) coef_plan[i] = poly_pkg::WORD_MIN;
		load_plan();
		send_point(poly_pkg::WORD_MIN, 1'b1);
		send_point(poly_pkg::WORD_MAX, 1'b1);
		send_point(ONE_Q, 1'b1);

		// x^7 minus one lsb, checks the floor shift on negative products
		drain();
		foreach (coef_plan[i]) coef_plan[i] = '0;
		coef_plan[7] = ONE_Q;
		coef_plan[0] = -32'sd1;
		load_plan();
		send_point(32'sh0002_0000, 1'b1);
		send_point(-32'sh0002_0000, 1'b1);
		send_point(32'sh0000_8000, 1'b1);
		send_point(-32'sd1, 1'b1);

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			drain();
			foreach (coef_plan[i]) coef_plan[i] = rand_coef();
			// some phases use a lower degree so the top terms are zero
			if (phase % 3 == 1) begin
				deg = $urandom_range(1, NUM_COEFFS - 1);
				for (int i = deg; i < poly_pkg::REG_COUNT; i++) coef_plan[i] = '0;
			end
			load_plan();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 2 && n == PHASE_ITEMS / 2)
					drain();
				send_point(rand_point(), phase != 4);
			end
		end

		drain();
		repeat (LATENCY) @(posedge clk);
		if (book.fails == 0 && book.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
